// File: rtl/arw_pkg.sv
// ----------------------------------------------------------------------------
// arw_pkg
// Types and codes shared by the anti-replay window block.
// ----------------------------------------------------------------------------
package arw_pkg;

    localparam int MapWidth = 64;
    localparam int SeqWidth = 32;

    // operation codes; the spare code behaves as a plain check
    localparam logic [1:0] OP_CHECK  = 2'd0;
    localparam logic [1:0] OP_COMMIT = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // classification codes
    localparam logic [1:0] ST_UNSEEN = 2'd0;
    localparam logic [1:0] ST_DUP    = 2'd1;
    localparam logic [1:0] ST_OLD    = 2'd2;

    typedef struct packed {
        logic [1:0]          operation;
        logic [SeqWidth-1:0] sequence_req;
    } arw_req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic                committed;
        logic                window_valid;
        logic [SeqWidth-1:0] highest_seen;
        logic [MapWidth-1:0] seen_map;
    } arw_rsp_t;

    typedef struct packed {
        logic                window_on;
        logic [SeqWidth-1:0] top_sequence;
        logic [MapWidth-1:0] received_bits;
    } arw_state_t;

endpackage

// File: rtl/arw_in_stage.sv
// ----------------------------------------------------------------------------
// arw_in_stage
// Input register: holds one request until the update stage takes it.
// ----------------------------------------------------------------------------
module arw_in_stage
    import arw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  arw_req_t in_data,
    input  logic     take,
    output logic     held_valid,
    output arw_req_t held_data
);

    logic     valid_reg;
    logic     valid_next;
    arw_req_t data_reg;

    // empty, or the held request leaves this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

    assign held_valid = valid_reg;
    assign held_data  = data_reg;

endmodule

// File: rtl/arw_update.sv
// ----------------------------------------------------------------------------
// arw_update
// Classifies one sequence number against the window and forms the window
// state after the request.
// ----------------------------------------------------------------------------
module arw_update
    import arw_pkg::*;
#(
    parameter int WINDOW_SIZE = 64
)
(
    input  arw_req_t   req,
    input  arw_state_t cur,
    output logic [1:0] status,
    output logic       committed,
    output arw_state_t nxt
);

    localparam logic [MapWidth-1:0] WinMask = {MapWidth{1'b1}} >> (MapWidth - WINDOW_SIZE);
    localparam logic [SeqWidth-1:0] WinSize = SeqWidth'(WINDOW_SIZE);

    logic                above;
    logic [SeqWidth-1:0] gap;
    logic [SeqWidth-1:0] jump;
    logic [5:0]          gap_idx;
    logic [5:0]          jump_idx;
    logic [MapWidth-1:0] shifted;

    assign above    = req.sequence_req > cur.top_sequence;
    assign gap      = cur.top_sequence - req.sequence_req;
    assign jump     = req.sequence_req - cur.top_sequence;
    assign gap_idx  = gap[5:0];
    assign jump_idx = jump[5:0];
    assign shifted  = ((cur.received_bits << jump_idx) | MapWidth'(1)) & WinMask;

    always_comb
    begin
        if (!cur.window_on || above)
        begin
            status = ST_UNSEEN;
        end
        else if (gap >= WinSize)
        begin
            status = ST_OLD;
        end
        else if (cur.received_bits[gap_idx])
        begin
            status = ST_DUP;
        end
        else
        begin
            status = ST_UNSEEN;
        end
    end

    always_comb
    begin
        nxt       = cur;
        committed = 1'b0;
        if (req.operation == OP_CLEAR)
        begin
            nxt = '0;
        end
        else if (req.operation == OP_COMMIT && status == ST_UNSEEN)
        begin
            committed = 1'b1;
            if (!cur.window_on)
            begin
                nxt.window_on     = 1'b1;
                nxt.top_sequence  = req.sequence_req;
                nxt.received_bits = MapWidth'(1);
            end
            else if (above)
            begin
                nxt.top_sequence  = req.sequence_req;
                nxt.received_bits = (jump >= WinSize) ? MapWidth'(1) : shifted;
            end
            else
            begin
                // older than the top but inside the window
                nxt.received_bits = cur.received_bits | (MapWidth'(1) << gap_idx);
            end
        end
    end

endmodule

// File: rtl/anti_replay_window.sv
// ----------------------------------------------------------------------------
// anti_replay_window
// Sliding-window anti-replay check over 32-bit sequence numbers.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  carries requests (operation, sequence_req) with valid/ready.
//   out_* carries one result per request: the classification against the
//   window before the request, the commit flag and the window after it.
//   A request is held in an input register; once the output register can
//   take a result, it is checked, the window state is updated and the
//   result is loaded into the output register. Throughput is one request
//   per cycle while the output is not stalled: the window state is one
//   register set updated by compare, subtract and 64-bit shift logic, so
//   each request sees the state left by the one before it.
//   When out_ready is low the result waits in the output register and one
//   more request can still be taken into the input register; after that
//   in_ready drops until the result is transferred.
//   Reset closes the window: no number is recorded, highest is zero and the
//   bitmap is empty. A clear request does the same at run time.
// ----------------------------------------------------------------------------
module anti_replay_window
    import arw_pkg::*;
#(
    parameter int WINDOW_SIZE = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  arw_req_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output arw_rsp_t out_data
);

    logic       held_valid;
    arw_req_t   held_data;
    logic       take;
    logic [1:0] status;
    logic       committed;
    arw_state_t state_reg;
    arw_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    arw_rsp_t   out_data_reg;

    assign take           = held_valid && (!out_valid_reg || out_ready);
    assign out_valid_next = take || (out_valid_reg && !out_ready);

    arw_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .take       (take),
        .held_valid (held_valid),
        .held_data  (held_data)
    );

    arw_update #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_update (
        .req       (held_data),
        .cur       (state_reg),
        .status    (status),
        .committed (committed),
        .nxt       (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg.status       <= status;
            out_data_reg.committed    <= committed;
            out_data_reg.window_valid <= state_next.window_on;
            out_data_reg.highest_seen <= state_next.top_sequence;
            out_data_reg.seen_map     <= state_next.received_bits;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/arw_checker.sv
// ----------------------------------------------------------------------------
// arw_checker
// Port-level checks for the anti-replay window, bound to the top level.
// ----------------------------------------------------------------------------
module arw_checker
    import arw_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input arw_req_t in_data,
    input logic     out_valid,
    input logic     out_ready,
    input arw_rsp_t out_data
);

    // a waiting request holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("request changed while waiting");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // only an unseen number can be committed, and a commit opens the window
    a_commit_unseen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.committed |->
            out_data.status == ST_UNSEEN && out_data.window_valid)
        else $error("commit of a number that was not unseen");

    // a closed window carries no history
    a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.window_valid |->
            out_data.highest_seen == '0 && out_data.seen_map == '0)
        else $error("closed window with recorded state");

    // the highest number is always marked as received
    a_top_marked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.window_valid |-> out_data.seen_map[0])
        else $error("highest number not marked in bitmap");

endmodule

bind anti_replay_window arw_checker u_arw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
